/* src/fsmb_pkg.sv */
// ----------------------------------------------------------------------------
// fsmb_pkg
// Shared types and codes of the synchronization mailbox.
// ----------------------------------------------------------------------------
`default_nettype none

package fsmb_pkg;

    // Operation codes of an input item.
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Status codes of a result item.
    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_ERROR   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_WAKE    = 3'd3,
        ST_RELEASE = 3'd4
    } status_t;

    // Synchronization modes; the unused code behaves as exclusive.
    localparam logic [1:0] MODE_EXCL   = 2'd0;
    localparam logic [1:0] MODE_SHARED = 2'd1;
    localparam logic [1:0] MODE_QUEUE  = 2'd2;

    // State of the single-value future.
    typedef enum logic [1:0] {
        FS_EMPTY   = 2'd0,
        FS_WAITING = 2'd1,
        FS_READY   = 2'd2
    } fut_state_t;

    // Configuration register indexes.
    localparam logic REG_SYNC_MODE = 1'b0;
    localparam logic REG_QUEUE_CAP = 1'b1;

    // Controller sequence.
    typedef enum logic [2:0] {
        C_IDLE,
        C_FETCH,
        C_DECIDE,
        C_SH_READ,
        C_SH_EMIT,
        C_FINAL
    } ctrl_state_t;

    localparam int IN_BYTES_W  = 48;
    localparam int OUT_BYTES_W = 48;

endpackage

`default_nettype wire

/* src/fsmb_ram.sv */
// ----------------------------------------------------------------------------
// fsmb_ram
// Single-port-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/future_sync_mailbox_unit.sv */
// ----------------------------------------------------------------------------
// future_sync_mailbox_unit
// Hardware future used as a mailbox: exclusive, shared and queue modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (set or get from a process) enter on s_tvalid/s_tready.
//   Result items leave on m_tvalid/m_tready; m_tlast marks the caller's own
//   result, which always comes after any wake or release results.
//   Configuration (mode, queue capacity) is written through cfg_we, cfg_index
//   and cfg_data while the block is idle.
//   Timing: one item is taken at a time. An item that yields one result passes
//   through the fetch and decide states before its result is loaded into the
//   output register; one with a wake or release then goes on to the final state.
//   A shared-mode set wakes each queued getter in turn, reading each waiter id
//   from the waiter memory through its registered read port. The next item can
//   be accepted the cycle after the last result enters the output register.
//   Reset clears all pointers, counts and the future state; the memories
//   need no clearing since only entries below the counts are read.
//   When the receiver stalls, the result waits in the output register and
//   the controller holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module future_sync_mailbox_unit #(
    parameter int RING_DEPTH   = 16,
    parameter int WAITER_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Fields from bit 0: operation, process_id[7:0], value[31:0], zero fill.
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: status[2:0], target_process[7:0], result_value[31:0].
    output logic      [47:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [4:0]  cfg_data
);

    import fsmb_pkg::*;

    localparam int SETTER_DEPTH = (RING_DEPTH > WAITER_DEPTH) ? RING_DEPTH : WAITER_DEPTH;
    localparam int WAW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SAW = (SETTER_DEPTH > 1) ? $clog2(SETTER_DEPTH) : 1;
    localparam int WCW = $clog2(WAITER_DEPTH + 1);
    localparam int RCW = $clog2(RING_DEPTH + 1);
    localparam int SCW = $clog2(SETTER_DEPTH + 1);
    localparam int CAPW = (RCW > 5) ? RCW : 5;

    // Control and architectural state.
    ctrl_state_t      state_reg, state_next;
    fut_state_t       fs_reg, fs_next;
    logic [31:0]      held_reg, held_next;
    logic [1:0]       mode_reg;
    logic [4:0]       cap_reg;
    logic [WAW-1:0]   wh_reg, wh_next;
    logic [WCW-1:0]   wc_reg, wc_next;
    logic [RAW-1:0]   rh_reg, rh_next, rt_reg, rt_next;
    logic [RCW-1:0]   rc_reg, rc_next;
    logic [SAW-1:0]   sh_reg, sh_next;
    logic [SCW-1:0]   sc_reg, sc_next;

    // Latched input item and pending final result.
    logic             op_reg;
    logic [7:0]       pid_reg;
    logic [31:0]      val_reg;
    status_t          fin_st_reg, fin_st_next;
    logic [31:0]      fin_val_reg, fin_val_next;

    // Output register.
    logic             out_valid_reg;
    status_t          out_st_reg;
    logic [7:0]       out_pid_reg;
    logic [31:0]      out_val_reg;
    logic             out_last_reg;

    // Memory ports.
    logic             w_we, r_we, s_we;
    logic [WAW-1:0]   w_waddr;
    logic [RAW-1:0]   r_waddr;
    logic [SAW-1:0]   s_waddr;
    logic [31:0]      r_wdata;
    logic [39:0]      s_wdata;
    logic [7:0]       w_rdata;
    logic [31:0]      r_rdata;
    logic [39:0]      s_rdata;

    // Emission and decision signals.
    logic             slot_free;
    logic             emit;
    status_t          emit_st;
    logic [7:0]       emit_pid;
    logic [31:0]      emit_val;
    logic             emit_last;
    logic             go_final, go_shread;

    logic [CAPW-1:0]  cap_eff;
    logic [CAPW-1:0]  rc_ext;
    logic [WAW:0]     w_tail_sum;
    logic [SAW:0]     s_tail_sum;
    logic [WAW-1:0]   w_tail;
    logic [SAW-1:0]   s_tail;
    logic [WAW-1:0]   wh_inc;
    logic [RAW-1:0]   rh_inc, rt_inc;
    logic [SAW-1:0]   sh_inc;
    logic             w_full, s_full;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == C_IDLE);

    // Effective capacity, clamped to 1..RING_DEPTH.
    always_comb
    begin
        cap_eff = CAPW'(cap_reg);
        if (cap_reg == 5'd0)
        begin
            cap_eff = CAPW'(1);
        end
        else if (CAPW'(cap_reg) > CAPW'(RING_DEPTH))
        begin
            cap_eff = CAPW'(RING_DEPTH);
        end
        rc_ext = CAPW'(rc_reg);
    end

    // Pointer arithmetic modulo each depth.
    always_comb
    begin
        w_tail_sum = (WAW+1)'(wh_reg) + (WAW+1)'(wc_reg);
        if (w_tail_sum >= (WAW+1)'(WAITER_DEPTH))
        begin
            w_tail_sum = w_tail_sum - (WAW+1)'(WAITER_DEPTH);
        end
        w_tail = w_tail_sum[WAW-1:0];
        s_tail_sum = (SAW+1)'(sh_reg) + (SAW+1)'(sc_reg);
        if (s_tail_sum >= (SAW+1)'(SETTER_DEPTH))
        begin
            s_tail_sum = s_tail_sum - (SAW+1)'(SETTER_DEPTH);
        end
        s_tail = s_tail_sum[SAW-1:0];
        wh_inc = (wh_reg == WAW'(WAITER_DEPTH - 1)) ? '0 : wh_reg + WAW'(1);
        rh_inc = (rh_reg == RAW'(RING_DEPTH - 1)) ? '0 : rh_reg + RAW'(1);
        rt_inc = (rt_reg == RAW'(RING_DEPTH - 1)) ? '0 : rt_reg + RAW'(1);
        sh_inc = (sh_reg == SAW'(SETTER_DEPTH - 1)) ? '0 : sh_reg + SAW'(1);
        w_full = (wc_reg >= WCW'(WAITER_DEPTH));
        s_full = (sc_reg >= SCW'(SETTER_DEPTH));
    end

    // Decision datapath: results, state updates and memory writes.
    always_comb
    begin
        emit = 1'b0;
        emit_st = ST_DONE;
        emit_pid = pid_reg;
        emit_val = 32'd0;
        emit_last = 1'b1;
        go_final = 1'b0;
        go_shread = 1'b0;
        fin_st_next = fin_st_reg;
        fin_val_next = fin_val_reg;
        fs_next = fs_reg;
        held_next = held_reg;
        wh_next = wh_reg;
        wc_next = wc_reg;
        rh_next = rh_reg;
        rt_next = rt_reg;
        rc_next = rc_reg;
        sh_next = sh_reg;
        sc_next = sc_reg;
        w_we = 1'b0;
        w_waddr = w_tail;
        r_we = 1'b0;
        r_waddr = rt_reg;
        r_wdata = val_reg;
        s_we = 1'b0;
        s_waddr = s_tail;
        s_wdata = {pid_reg, val_reg};
        unique case (state_reg)
            C_DECIDE:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (mode_reg == MODE_QUEUE)
                    begin
                        if (op_reg == OP_SET)
                        begin
                            if (rc_reg == '0 && wc_reg != '0)
                            begin
                                emit_st = ST_WAKE;
                                emit_pid = w_rdata;
                                emit_val = val_reg;
                                emit_last = 1'b0;
                                wh_next = wh_inc;
                                wc_next = wc_reg - WCW'(1);
                                fin_st_next = ST_DONE;
                                fin_val_next = 32'd0;
                                go_final = 1'b1;
                            end
                            else if (rc_ext >= cap_eff)
                            begin
                                if (!s_full)
                                begin
                                    s_we = 1'b1;
                                    sc_next = sc_reg + SCW'(1);
                                    emit_st = ST_BLOCKED;
                                end
                                else
                                begin
                                    emit_st = ST_ERROR;
                                end
                            end
                            else
                            begin
                                r_we = 1'b1;
                                rt_next = rt_inc;
                                rc_next = rc_reg + RCW'(1);
                            end
                        end
                        else
                        begin
                            if (rc_reg != '0)
                            begin
                                rh_next = rh_inc;
                                if (sc_reg != '0 && (rc_ext - CAPW'(1)) < cap_eff)
                                begin
                                    // Refill the freed slot from the head setter.
                                    r_we = 1'b1;
                                    r_wdata = s_rdata[31:0];
                                    rt_next = rt_inc;
                                    sh_next = sh_inc;
                                    sc_next = sc_reg - SCW'(1);
                                    emit_st = ST_RELEASE;
                                    emit_pid = s_rdata[39:32];
                                    emit_last = 1'b0;
                                    fin_st_next = ST_DONE;
                                    fin_val_next = r_rdata;
                                    go_final = 1'b1;
                                end
                                else
                                begin
                                    rc_next = rc_reg - RCW'(1);
                                    emit_val = r_rdata;
                                end
                            end
                            else if (sc_reg != '0)
                            begin
                                sh_next = sh_inc;
                                sc_next = sc_reg - SCW'(1);
                                emit_st = ST_RELEASE;
                                emit_pid = s_rdata[39:32];
                                emit_last = 1'b0;
                                fin_st_next = ST_DONE;
                                fin_val_next = s_rdata[31:0];
                                go_final = 1'b1;
                            end
                            else if (!w_full)
                            begin
                                w_we = 1'b1;
                                wc_next = wc_reg + WCW'(1);
                                emit_st = ST_BLOCKED;
                            end
                            else
                            begin
                                emit_st = ST_ERROR;
                            end
                        end
                    end
                    else if (mode_reg == MODE_SHARED)
                    begin
                        if (op_reg == OP_SET)
                        begin
                            if (fs_reg == FS_READY)
                            begin
                                emit_st = ST_ERROR;
                            end
                            else
                            begin
                                held_next = val_reg;
                                fs_next = FS_READY;
                                if (wc_reg != '0)
                                begin
                                    emit_st = ST_WAKE;
                                    emit_pid = w_rdata;
                                    emit_val = val_reg;
                                    emit_last = 1'b0;
                                    wh_next = wh_inc;
                                    wc_next = wc_reg - WCW'(1);
                                    fin_st_next = ST_DONE;
                                    fin_val_next = 32'd0;
                                    go_shread = (wc_reg != WCW'(1));
                                    go_final = (wc_reg == WCW'(1));
                                end
                            end
                        end
                        else
                        begin
                            if (fs_reg == FS_READY)
                            begin
                                emit_val = held_reg;
                            end
                            else if (!w_full)
                            begin
                                w_we = 1'b1;
                                wc_next = wc_reg + WCW'(1);
                                fs_next = FS_WAITING;
                                emit_st = ST_BLOCKED;
                            end
                            else
                            begin
                                emit_st = ST_ERROR;
                            end
                        end
                    end
                    else
                    begin
                        if (op_reg == OP_SET)
                        begin
                            if (fs_reg == FS_READY)
                            begin
                                emit_st = ST_ERROR;
                            end
                            else if (fs_reg == FS_WAITING && wc_reg != '0)
                            begin
                                held_next = val_reg;
                                emit_st = ST_WAKE;
                                emit_pid = w_rdata;
                                emit_val = val_reg;
                                emit_last = 1'b0;
                                wh_next = wh_inc;
                                wc_next = wc_reg - WCW'(1);
                                fs_next = (wc_reg != WCW'(1)) ? FS_WAITING : FS_EMPTY;
                                fin_st_next = ST_DONE;
                                fin_val_next = 32'd0;
                                go_final = 1'b1;
                            end
                            else
                            begin
                                held_next = val_reg;
                                fs_next = FS_READY;
                            end
                        end
                        else
                        begin
                            if (fs_reg == FS_READY)
                            begin
                                fs_next = FS_EMPTY;
                                emit_val = held_reg;
                            end
                            else if (fs_reg == FS_WAITING)
                            begin
                                emit_st = ST_ERROR;
                            end
                            else if (!w_full)
                            begin
                                w_we = 1'b1;
                                wc_next = wc_reg + WCW'(1);
                                fs_next = FS_WAITING;
                                emit_st = ST_BLOCKED;
                            end
                            else
                            begin
                                emit_st = ST_ERROR;
                            end
                        end
                    end
                end
            end
            C_SH_EMIT:
            begin
                // Broadcast wake of the next queued getter.
                if (slot_free)
                begin
                    emit = 1'b1;
                    emit_st = ST_WAKE;
                    emit_pid = w_rdata;
                    emit_val = val_reg;
                    emit_last = 1'b0;
                    wh_next = wh_inc;
                    wc_next = wc_reg - WCW'(1);
                    go_shread = (wc_reg != WCW'(1));
                    go_final = (wc_reg == WCW'(1));
                end
            end
            C_FINAL:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    emit_st = fin_st_reg;
                    emit_val = fin_val_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Next-state sequencing.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = C_FETCH;
                end
            end
            C_FETCH:
            begin
                state_next = C_DECIDE;
            end
            C_DECIDE, C_SH_EMIT:
            begin
                if (emit)
                begin
                    priority if (go_shread)
                    begin
                        state_next = C_SH_READ;
                    end
                    else if (go_final)
                    begin
                        state_next = C_FINAL;
                    end
                    else
                    begin
                        state_next = C_IDLE;
                    end
                end
            end
            C_SH_READ:
            begin
                state_next = C_SH_EMIT;
            end
            C_FINAL:
            begin
                if (emit)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            fs_reg <= FS_EMPTY;
            held_reg <= 32'd0;
            mode_reg <= MODE_EXCL;
            cap_reg <= 5'd16;
            wh_reg <= '0;
            wc_reg <= '0;
            rh_reg <= '0;
            rt_reg <= '0;
            rc_reg <= '0;
            sh_reg <= '0;
            sc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fs_reg <= fs_next;
            held_reg <= held_next;
            wh_reg <= wh_next;
            wc_reg <= wc_next;
            rh_reg <= rh_next;
            rt_reg <= rt_next;
            rc_reg <= rc_next;
            sh_reg <= sh_next;
            sc_reg <= sc_next;
            if (cfg_we && cfg_index == REG_SYNC_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_we && cfg_index == REG_QUEUE_CAP)
            begin
                cap_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && s_tvalid)
        begin
            op_reg <= s_tdata[0];
            pid_reg <= s_tdata[8:1];
            val_reg <= s_tdata[40:9];
        end
        fin_st_reg <= fin_st_next;
        fin_val_reg <= fin_val_next;
        if (emit)
        begin
            out_st_reg <= emit_st;
            out_pid_reg <= emit_pid;
            out_val_reg <= emit_val;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_val_reg, out_pid_reg, out_st_reg};

    // Waiting getter ids.
    fsmb_ram #(.WIDTH(8), .DEPTH(WAITER_DEPTH), .AW(WAW)) u_waiter_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (pid_reg),
        .raddr (wh_reg),
        .rdata (w_rdata)
    );

    // Data ring of queue mode.
    fsmb_ram #(.WIDTH(32), .DEPTH(RING_DEPTH), .AW(RAW)) u_ring_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (rh_reg),
        .rdata (r_rdata)
    );

    // Blocked setters, process id over value.
    fsmb_ram #(.WIDTH(40), .DEPTH(SETTER_DEPTH), .AW(SAW)) u_setter_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (sh_reg),
        .rdata (s_rdata)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the future_sync_mailbox_unit synchronization mailbox.
// Directed tests cover the exclusive, shared and queue behaviors and their
// corner cases. Random phases then run under varied settings and stall
// patterns. A built-in model of the mailbox predicts every result item, and
// each item leaving the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import fsmb_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 50;

    typedef struct {
        status_t     st;
        logic [7:0]  pid;
        logic [31:0] val;
        logic        last;
    } mbox_result_t;

    logic        clk;
    logic        rst_n;
    logic [47:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    // Model state of the mailbox.
    logic [1:0]  mdl_mode;
    logic [4:0]  mdl_cap;
    fut_state_t  mdl_fut;
    logic [31:0] mdl_held;
    logic [7:0]  mdl_waiter [FIFO_DEPTH];
    int          mdl_w_head;
    int          mdl_w_count;
    logic [31:0] mdl_ring [FIFO_DEPTH];
    int          mdl_r_head;
    int          mdl_r_tail;
    int          mdl_r_count;
    logic [7:0]  mdl_setter_pid [FIFO_DEPTH];
    logic [31:0] mdl_setter_val [FIFO_DEPTH];
    int          mdl_s_head;
    int          mdl_s_count;

    mbox_result_t expected_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          recv_hold;
    int          mismatches;
    int unsigned cycles;

    future_sync_mailbox_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver side: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            recv_hold = recv_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares each accepted result item with the oldest prediction.
    always @(posedge clk)
    begin
        mbox_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item st=%0d pid=%0d val=%h last=%b",
                             m_tdata[2:0], m_tdata[10:3], m_tdata[42:11], m_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[2:0] !== want.st || m_tdata[10:3] !== want.pid ||
                    m_tdata[42:11] !== want.val || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp st=%0d pid=%0d val=%h last=%b, got st=%0d pid=%0d val=%h last=%b",
                                 want.st, want.pid, want.val, want.last,
                                 m_tdata[2:0], m_tdata[10:3], m_tdata[42:11], m_tlast);
                end
            end
        end
    end

    function automatic void emit(status_t st, logic [7:0] pid, logic [31:0] val, logic last);
        mbox_result_t r;
        r.st   = st;
        r.pid  = pid;
        r.val  = val;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic logic [7:0] waiter_pop();
        logic [7:0] p;
        p = mdl_waiter[mdl_w_head];
        mdl_w_head = (mdl_w_head + 1) % FIFO_DEPTH;
        mdl_w_count--;
        return p;
    endfunction

    function automatic bit waiter_push(logic [7:0] pid);
        if (mdl_w_count >= FIFO_DEPTH)
            return 1'b0;
        mdl_waiter[(mdl_w_head + mdl_w_count) % FIFO_DEPTH] = pid;
        mdl_w_count++;
        return 1'b1;
    endfunction

    function automatic void ring_push(logic [31:0] v);
        mdl_ring[mdl_r_tail] = v;
        mdl_r_tail = (mdl_r_tail + 1) % FIFO_DEPTH;
        mdl_r_count++;
    endfunction

    // Works out the result items caused by one accepted request.
    function automatic void predict_mailbox(logic op, logic [7:0] pid, logic [31:0] val);
        int          cap;
        logic [31:0] v;
        logic [7:0]  sp;
        cap = (mdl_cap < 1) ? 1 : ((mdl_cap > FIFO_DEPTH) ? FIFO_DEPTH : mdl_cap);
        if (mdl_mode == MODE_QUEUE)
        begin
            if (op == OP_SET)
            begin
                if (mdl_r_count == 0 && mdl_w_count > 0)
                begin
                    emit(ST_WAKE, waiter_pop(), val, 1'b0);
                    emit(ST_DONE, pid, 32'd0, 1'b1);
                end
                else if (mdl_r_count >= cap)
                begin
                    if (mdl_s_count < FIFO_DEPTH)
                    begin
                        mdl_setter_pid[(mdl_s_head + mdl_s_count) % FIFO_DEPTH] = pid;
                        mdl_setter_val[(mdl_s_head + mdl_s_count) % FIFO_DEPTH] = val;
                        mdl_s_count++;
                        emit(ST_BLOCKED, pid, 32'd0, 1'b1);
                    end
                    else
                    begin
                        emit(ST_ERROR, pid, 32'd0, 1'b1);
                    end
                end
                else
                begin
                    ring_push(val);
                    emit(ST_DONE, pid, 32'd0, 1'b1);
                end
            end
            else if (mdl_r_count > 0)
            begin
                v = mdl_ring[mdl_r_head];
                mdl_r_head = (mdl_r_head + 1) % FIFO_DEPTH;
                mdl_r_count--;
                if (mdl_s_count > 0 && mdl_r_count < cap)
                begin
                    sp = mdl_setter_pid[mdl_s_head];
                    ring_push(mdl_setter_val[mdl_s_head]);
                    mdl_s_head = (mdl_s_head + 1) % FIFO_DEPTH;
                    mdl_s_count--;
                    emit(ST_RELEASE, sp, 32'd0, 1'b0);
                end
                emit(ST_DONE, pid, v, 1'b1);
            end
            else if (mdl_s_count > 0)
            begin
                sp = mdl_setter_pid[mdl_s_head];
                v  = mdl_setter_val[mdl_s_head];
                mdl_s_head = (mdl_s_head + 1) % FIFO_DEPTH;
                mdl_s_count--;
                emit(ST_RELEASE, sp, 32'd0, 1'b0);
                emit(ST_DONE, pid, v, 1'b1);
            end
            else if (waiter_push(pid))
                emit(ST_BLOCKED, pid, 32'd0, 1'b1);
            else
                emit(ST_ERROR, pid, 32'd0, 1'b1);
        end
        else if (mdl_mode == MODE_SHARED)
        begin
            if (op == OP_SET)
            begin
                if (mdl_fut == FS_READY)
                    emit(ST_ERROR, pid, 32'd0, 1'b1);
                else
                begin
                    mdl_held = val;
                    mdl_fut  = FS_READY;
                    while (mdl_w_count > 0)
                        emit(ST_WAKE, waiter_pop(), val, 1'b0);
                    emit(ST_DONE, pid, 32'd0, 1'b1);
                end
            end
            else if (mdl_fut == FS_READY)
                emit(ST_DONE, pid, mdl_held, 1'b1);
            else if (waiter_push(pid))
            begin
                mdl_fut = FS_WAITING;
                emit(ST_BLOCKED, pid, 32'd0, 1'b1);
            end
            else
                emit(ST_ERROR, pid, 32'd0, 1'b1);
        end
        else
        begin
            // Exclusive mode; the unused mode code lands here too.
            if (op == OP_SET)
            begin
                if (mdl_fut == FS_READY)
                    emit(ST_ERROR, pid, 32'd0, 1'b1);
                else if (mdl_fut == FS_WAITING && mdl_w_count > 0)
                begin
                    mdl_held = val;
                    emit(ST_WAKE, waiter_pop(), val, 1'b0);
                    mdl_fut = (mdl_w_count > 0) ? FS_WAITING : FS_EMPTY;
                    emit(ST_DONE, pid, 32'd0, 1'b1);
                end
                else
                begin
                    mdl_held = val;
                    mdl_fut  = FS_READY;
                    emit(ST_DONE, pid, 32'd0, 1'b1);
                end
            end
            else if (mdl_fut == FS_READY)
            begin
                mdl_fut = FS_EMPTY;
                emit(ST_DONE, pid, mdl_held, 1'b1);
            end
            else if (mdl_fut == FS_WAITING)
                emit(ST_ERROR, pid, 32'd0, 1'b1);
            else if (waiter_push(pid))
            begin
                mdl_fut = FS_WAITING;
                emit(ST_BLOCKED, pid, 32'd0, 1'b1);
            end
            else
                emit(ST_ERROR, pid, 32'd0, 1'b1);
        end
    endfunction

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(logic op, logic [7:0] pid, logic [31:0] val);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, val, pid, op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_mailbox(op, pid, val);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register writes happen only once the block has drained.
    task automatic write_reg(logic idx, logic [4:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SYNC_MODE)
            mdl_mode = data[1:0];
        else
            mdl_cap = data;
    endtask

    task automatic test_exclusive();
        write_reg(REG_SYNC_MODE, {3'd0, MODE_EXCL});
        send_request(OP_GET, 8'd0, 32'hFFFF_FFFF);   // blocks
        send_request(OP_GET, 8'd255, 32'd0);         // error while waiting
        send_request(OP_SET, 8'd7, 32'hFFFF_FFFF);   // wakes getter, leaves empty
        send_request(OP_SET, 8'd255, 32'd0);         // becomes ready
        send_request(OP_SET, 8'd1, 32'h1234_5678);   // second set is an error
        send_request(OP_GET, 8'd128, 32'h0);         // takes the value
        send_request(OP_GET, 8'd9, 32'h0);           // blocks again
        // The unused mode code behaves as exclusive.
        write_reg(REG_SYNC_MODE, 5'd3);
        send_request(OP_SET, 8'd2, 32'hA5A5_5A5A);
    endtask

    task automatic test_shared();
        write_reg(REG_SYNC_MODE, {3'd0, MODE_SHARED});
        // Fill the waiter list, then overflow it.
        for (int i = 0; i < FIFO_DEPTH + 1; i++)
            send_request(OP_GET, 8'(i * 13), 32'h0);
        // One set wakes every waiter, a second one is refused.
        send_request(OP_SET, 8'd77, 32'hDEAD_BEEF);
        send_request(OP_SET, 8'd78, 32'h0);
        send_request(OP_GET, 8'd79, 32'h0);
        // Back in exclusive mode the ready value is taken once.
        write_reg(REG_SYNC_MODE, {3'd0, MODE_EXCL});
        send_request(OP_GET, 8'd80, 32'h0);
    endtask

    task automatic test_queue();
        write_reg(REG_SYNC_MODE, {3'd0, MODE_QUEUE});
        write_reg(REG_QUEUE_CAP, 5'd0);
        // Capacity zero acts as one: fill the setter list and overflow it.
        for (int i = 0; i < FIFO_DEPTH + 2; i++)
            send_request(OP_SET, 8'(200 + i), 32'h1000 + i);
        for (int i = 0; i < FIFO_DEPTH + 3; i++)
            send_request(OP_GET, 8'(i), 32'h0);
        // Getters queued on an empty ring get values directly.
        send_request(OP_SET, 8'd50, 32'hCAFE_0001);
        send_request(OP_SET, 8'd51, 32'hCAFE_0002);
        // Large capacity, then lowered below the fill.
        write_reg(REG_QUEUE_CAP, 5'd31);
        for (int i = 0; i < 6; i++)
            send_request(OP_SET, 8'(60 + i), $urandom);
        write_reg(REG_QUEUE_CAP, 5'd2);
        send_request(OP_SET, 8'd70, 32'h7070_7070);
        for (int i = 0; i < 8; i++)
            send_request(OP_GET, 8'(90 + i), 32'h0);
        write_reg(REG_QUEUE_CAP, 5'd16);
    endtask

    // Back-pressure: the receiver holds off while requests keep coming.
    task automatic test_backpressure();
        write_reg(REG_SYNC_MODE, {3'd0, MODE_QUEUE});
        recv_hold = 300;
        for (int i = 0; i < 12; i++)
            send_request(i[0], 8'($urandom), $urandom);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [4:0] caps [7];
        caps = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd16, 5'd31, 5'd8};
        write_reg(REG_SYNC_MODE, 5'($urandom_range(3)));
        write_reg(REG_QUEUE_CAP, ($urandom_range(3) == 0) ? 5'($urandom) :
                                 caps[$urandom_range(6)]);
        for (int i = 0; i < count; i++)
        begin
            send_request($urandom_range(1), 8'($urandom), $urandom);
            // Once per phase, let everything drain before going on.
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        recv_hold = 0;
        mismatches = 0;
        cycles    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 54;
        mdl_mode = MODE_EXCL;
        mdl_cap  = 5'd16;
        mdl_fut  = FS_EMPTY;
        mdl_held = '0;
        mdl_w_head = 0;
        mdl_w_count = 0;
        mdl_r_head = 0;
        mdl_r_tail = 0;
        mdl_r_count = 0;
        mdl_s_head = 0;
        mdl_s_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_exclusive();
        test_shared();
        test_queue();
        test_backpressure();

        // Random phases under each stall pattern.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 28;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            test_random(10);
        end

        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/fsmb_pkg.sv
src/fsmb_ram.sv
src/future_sync_mailbox_unit.sv
dv/tb_top.sv
